// File: rtl/core/utp_pkg.sv
// shared types, register codes and byte constants for the text paginator
package utp_pkg;

  localparam int LINE_BITS  = 6;
  localparam int WIDTH_BITS = 8;

  localparam logic [0:0] CFG_LINE_LIMIT = 1'b0;
  localparam logic [0:0] CFG_LINE_WIDTH = 1'b1;

  localparam logic [LINE_BITS-1:0]  LINE_LIMIT_RST = 6'd12;
  localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RST = 8'd44;

  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

  localparam logic [1:0] EMPTY_RUN_MAX = 2'd3;

  typedef struct packed {
    logic       page_start;
    logic       end_of_file;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [LINE_BITS-1:0] newlines_before;
    logic                 byte_valid;
    logic [7:0]           out_byte;
    logic                 page_end;
  } res_t;

  // number of continuation bytes that follow a lead byte
  function automatic logic [1:0] cont_count(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_CODE) n = 2'd1;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) n = 2'd2;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) n = 2'd3;
    return n;
  endfunction

  // display width in half-width units
  function automatic logic [1:0] glyph_units(input logic [7:0] b);
    logic [1:0] w;
    w = 2'd1;
    if (b >= ASCII_TOP && cont_count(b) != 2'd0) w = 2'd2;
    return w;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHR_LF) || (b == CHR_CR) || (b == CHR_SP) || (b == CHR_TAB);
  endfunction

endpackage

// File: rtl/core/utp_in_if.sv
// input and result channel interfaces of the text paginator
interface utp_in_if #(parameter int OFFSET_BITS = 32);
  logic                   valid;
  logic                   ready;
  logic                   page_start;
  logic                   end_of_file;
  logic [7:0]             data_byte;
  logic [OFFSET_BITS-1:0] byte_offset;

  modport source (output valid, page_start, end_of_file, data_byte, byte_offset,
                  input ready);
  modport sink (input valid, page_start, end_of_file, data_byte, byte_offset,
                output ready);
endinterface

interface utp_out_if #(parameter int OFFSET_BITS = 32);
  logic                   valid;
  logic                   ready;
  logic [5:0]             newlines_before;
  logic                   byte_valid;
  logic [7:0]             out_byte;
  logic                   page_end;
  logic [OFFSET_BITS-1:0] next_offset;

  modport source (output valid, newlines_before, byte_valid, out_byte, page_end,
                  next_offset, input ready);
  modport sink (input valid, newlines_before, byte_valid, out_byte, page_end,
                next_offset, output ready);
endinterface

// File: rtl/core/utp_layout.sv
// layout state, configuration registers and the per-item update
module utp_layout
  import utp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  item_t                  item,
  input  logic [OFFSET_BITS-1:0] item_ofs,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [7:0]             cfg_wdata,
  output logic                   res_have,
  output res_t                   res,
  output logic [OFFSET_BITS-1:0] res_ofs
);

  logic [LINE_BITS-1:0]  line_limit_r;
  logic [WIDTH_BITS-1:0] line_width_r;

  logic [LINE_BITS-1:0]  line_count_r, line_count_nxt;
  logic [WIDTH_BITS-1:0] width_used_r, width_used_nxt;
  logic [1:0]            empty_run_r, empty_run_nxt;
  logic                  has_text_r, has_text_nxt;
  logic [1:0]            cont_left_r, cont_left_nxt;
  logic                  skipping_r, skipping_nxt;
  logic                  finished_r, finished_nxt;

  logic                  go;
  logic [LINE_BITS-1:0]  held;
  logic [1:0]            cw;
  logic [8:0]            wsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LINE_LIMIT_RST;
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_LIMIT: line_limit_r <= cfg_wdata[LINE_BITS-1:0];
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (item.page_start) begin
      line_count_nxt = '0;
      width_used_nxt = '0;
      empty_run_nxt  = '0;
      has_text_nxt   = 1'b0;
      cont_left_nxt  = '0;
      skipping_nxt   = 1'b0;
      finished_nxt   = 1'b0;
    end else begin
      line_count_nxt = line_count_r;
      width_used_nxt = width_used_r;
      empty_run_nxt  = empty_run_r;
      has_text_nxt   = has_text_r;
      cont_left_nxt  = cont_left_r;
      skipping_nxt   = skipping_r;
      finished_nxt   = finished_r;
    end
    res_have = 1'b0;
    res      = '0;
    res_ofs  = '0;
    go       = 1'b0;
    held     = '0;
    cw       = glyph_units(item.data_byte);
    wsum     = '0;

    if (!finished_nxt) begin
      if (line_count_nxt >= line_limit_r) begin
        res_have            = 1'b1;
        res.newlines_before = has_text_nxt ? '0 : line_count_nxt;
        res.page_end        = 1'b1;
        res_ofs             = item_ofs;
        finished_nxt        = 1'b1;
      end else if (item.end_of_file) begin
        res_have            = 1'b1;
        res.newlines_before = (has_text_nxt || skipping_nxt) ? '0 : line_count_nxt;
        res.page_end        = 1'b1;
        res_ofs             = item_ofs;
        finished_nxt        = 1'b1;
      end else if (cont_left_nxt != 2'd0) begin
        cont_left_nxt  = cont_left_nxt - 2'd1;
        res_have       = 1'b1;
        res.byte_valid = 1'b1;
        res.out_byte   = item.data_byte;
      end else begin
        go = 1'b1;
        if (skipping_nxt) begin
          if (is_blank(item.data_byte)) begin
            go = 1'b0;
          end else begin
            skipping_nxt = 1'b0;
            if (has_text_nxt) begin
              // chapter break after text: end here, byte not consumed
              go           = 1'b0;
              res_have     = 1'b1;
              res.page_end = 1'b1;
              res_ofs      = item_ofs;
              finished_nxt = 1'b1;
            end else begin
              line_count_nxt = '0;
              width_used_nxt = '0;
              empty_run_nxt  = '0;
            end
          end
        end

        if (go && item.data_byte == CHR_LF) begin
          if (width_used_nxt == '0) begin
            if (empty_run_nxt != EMPTY_RUN_MAX) empty_run_nxt = empty_run_nxt + 2'd1;
          end else begin
            empty_run_nxt = '0;
          end
          if (empty_run_nxt == EMPTY_RUN_MAX) begin
            skipping_nxt = 1'b1;
          end else begin
            line_count_nxt = line_count_nxt + 1'b1;
            width_used_nxt = '0;
            if (line_count_nxt >= line_limit_r) begin
              res_have     = 1'b1;
              res.page_end = 1'b1;
              res_ofs      = item_ofs + OFFSET_BITS'(1);
              finished_nxt = 1'b1;
              if (has_text_nxt) begin
                res.byte_valid = 1'b1;
                res.out_byte   = CHR_LF;
              end else begin
                res.newlines_before = line_count_nxt;
              end
            end else if (has_text_nxt) begin
              res_have       = 1'b1;
              res.byte_valid = 1'b1;
              res.out_byte   = CHR_LF;
            end
          end
        end else if (go && item.data_byte != CHR_CR) begin
          held          = has_text_nxt ? '0 : line_count_nxt;
          has_text_nxt  = 1'b1;
          empty_run_nxt = '0;
          wsum          = {1'b0, width_used_nxt} + {7'd0, cw};
          res_have      = 1'b1;
          if (wsum > {1'b0, line_width_r}) begin
            held           = held + 1'b1;
            line_count_nxt = line_count_nxt + 1'b1;
            width_used_nxt = '0;
          end
          res.newlines_before = held;
          if (line_count_nxt >= line_limit_r) begin
            // wrap hit the line limit: character goes to the next page
            res.page_end = 1'b1;
            res_ofs      = item_ofs;
            finished_nxt = 1'b1;
          end else begin
            width_used_nxt = width_used_nxt + {6'd0, cw};
            cont_left_nxt  = cont_count(item.data_byte);
            res.byte_valid = 1'b1;
            res.out_byte   = item.data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      width_used_r <= '0;
      empty_run_r  <= '0;
      has_text_r   <= 1'b0;
      cont_left_r  <= '0;
      skipping_r   <= 1'b0;
      finished_r   <= 1'b0;
    end else if (step) begin
      line_count_r <= line_count_nxt;
      width_used_r <= width_used_nxt;
      empty_run_r  <= empty_run_nxt;
      has_text_r   <= has_text_nxt;
      cont_left_r  <= cont_left_nxt;
      skipping_r   <= skipping_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule

// File: rtl/core/utp_out_stage.sv
// result register driving the result channel
module utp_out_stage
  import utp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   res,
  input  logic [OFFSET_BITS-1:0] res_ofs,
  output logic                   busy,
  utp_out_if.source              out_ch
);

  logic                   valid_r;
  res_t                   res_r;
  logic [OFFSET_BITS-1:0] ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
      ofs_r <= res_ofs;
    end
  end

  assign busy                   = valid_r && !out_ch.ready;
  assign out_ch.valid           = valid_r;
  assign out_ch.newlines_before = res_r.newlines_before;
  assign out_ch.byte_valid      = res_r.byte_valid;
  assign out_ch.out_byte        = res_r.out_byte;
  assign out_ch.page_end        = res_r.page_end;
  assign out_ch.next_offset     = ofs_r;

endmodule

// File: rtl/core/utp_text_paginator_top.sv
// top level of the utf-8 text paginator
//
//   port      dir  handshake     contents
//   in_ch     in   valid/ready   page_start, end_of_file, data_byte, byte_offset
//   out_ch    out  valid/ready   newlines_before, byte_valid, out_byte, page_end, next_offset
//   cfg_*     in   write enable  line limit (index 0), line_width_units (index 1)
//
// one item per cycle while the result register is not stalled; a result passes from
// the input register through the layout update into the result register
// items that make no result only update the layout state
// a stalled result register holds the input register; input still fills an empty slot
// synchronous active-low reset clears the layout state and loads register defaults
module utf8_text_paginator
  import utp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  utp_in_if.sink     in_ch,
  utp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic                   in_valid_r;
  item_t                  item_r;
  logic [OFFSET_BITS-1:0] ofs_r;
  logic                   step;
  logic                   out_busy;
  logic                   res_have;
  res_t                   res;
  logic [OFFSET_BITS-1:0] res_ofs;

  assign step        = in_valid_r && !out_busy;
  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.page_start  <= in_ch.page_start;
      item_r.end_of_file <= in_ch.end_of_file;
      item_r.data_byte   <= in_ch.data_byte;
      ofs_r              <= in_ch.byte_offset;
    end
  end

  utp_layout #(.OFFSET_BITS(OFFSET_BITS)) u_layout (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item_r),
    .item_ofs  (ofs_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_have  (res_have),
    .res       (res),
    .res_ofs   (res_ofs)
  );

  utp_out_stage #(.OFFSET_BITS(OFFSET_BITS)) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step && res_have),
    .res     (res),
    .res_ofs (res_ofs),
    .busy    (out_busy),
    .out_ch  (out_ch)
  );

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the utf-8 text paginator
`timescale 1ns / 100ps

module tb_top;
  import utp_pkg::*;

  localparam int OFS_BITS     = 32;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 10;

  typedef struct {
    logic [5:0]          newlines;
    logic                has_byte;
    logic [7:0]          text_byte;
    logic                ends_page;
    logic [OFS_BITS-1:0] next_start;
  } page_out_t;

  logic clk;
  logic rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_wdata;

  utp_in_if  #(.OFFSET_BITS(OFS_BITS)) in_ch ();
  utp_out_if #(.OFFSET_BITS(OFS_BITS)) out_ch ();

  utf8_text_paginator #(.OFFSET_BITS(OFS_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // layout predictor state
  logic [5:0]          page_lines_cfg;
  logic [7:0]          page_width_cfg;
  logic [5:0]          lay_lines;
  logic [7:0]          lay_width;
  logic [1:0]          lay_empty;
  logic                lay_has_text;
  logic [1:0]          lay_cont;
  logic                lay_skipping;
  logic                lay_finished;
  logic [OFS_BITS-1:0] next_page_ofs;

  page_out_t  layout_due[$];
  logic [7:0] byte_fifo[$];

  int  error_count;
  int  results_seen;
  int  cycle_count;
  int  hold_off;
  bit  no_idle;
  bit  last_live;
  bit  start_pending;
  logic [OFS_BITS-1:0] file_pos;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL utf8_text_paginator");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at result %0d", what, got, want, results_seen);
    error_count++;
  endtask

  task automatic clear_layout();
    lay_lines    = '0;
    lay_width    = '0;
    lay_empty    = '0;
    lay_has_text = 1'b0;
    lay_cont     = '0;
    lay_skipping = 1'b0;
    lay_finished = 1'b0;
  endtask

  task automatic push_result(input int nl, input bit bv, input logic [7:0] b, input bit pe,
                             input logic [OFS_BITS-1:0] nx);
    page_out_t r;
    r.newlines   = nl[5:0];
    r.has_byte   = bv;
    r.text_byte  = bv ? b : 8'h00;
    r.ends_page  = pe;
    r.next_start = pe ? nx : '0;
    if (pe) begin
      lay_finished  = 1'b1;
      next_page_ofs = nx;
    end
    layout_due.push_back(r);
  endtask

  task automatic lay_out_item(input logic ps, input logic eof, input logic [7:0] b,
                              input logic [OFS_BITS-1:0] ofs);
    int held;
    int cw;
    logic [1:0] cont;
    last_live = 1'b0;
    if (ps) clear_layout();
    if (lay_finished) return;
    last_live = 1'b1;
    if (lay_lines >= page_lines_cfg) begin
      push_result(lay_has_text ? 0 : int'(lay_lines), 1'b0, 8'h00, 1'b1, ofs);
      return;
    end
    if (eof) begin
      push_result((lay_has_text || lay_skipping) ? 0 : int'(lay_lines), 1'b0, 8'h00, 1'b1,
                  ofs);
      return;
    end
    if (lay_cont != 2'd0) begin
      lay_cont = lay_cont - 2'd1;
      push_result(0, 1'b1, b, 1'b0, '0);
      return;
    end
    if (lay_skipping) begin
      if (b == CHR_LF || b == CHR_CR || b == CHR_SP || b == CHR_TAB) return;
      lay_skipping = 1'b0;
      if (lay_has_text) begin
        push_result(0, 1'b0, 8'h00, 1'b1, ofs);
        return;
      end
      lay_lines = '0;
      lay_width = '0;
      lay_empty = '0;
    end
    if (b == CHR_CR) return;
    if (b == CHR_LF) begin
      if (lay_width == 8'd0) begin
        if (lay_empty < EMPTY_RUN_MAX) lay_empty = lay_empty + 2'd1;
      end else begin
        lay_empty = '0;
      end
      if (lay_empty >= EMPTY_RUN_MAX) begin
        lay_skipping = 1'b1;
        return;
      end
      lay_lines = lay_lines + 6'd1;
      lay_width = '0;
      if (lay_lines >= page_lines_cfg) begin
        if (lay_has_text) push_result(0, 1'b1, CHR_LF, 1'b1, ofs + 1'b1);
        else push_result(int'(lay_lines), 1'b0, 8'h00, 1'b1, ofs + 1'b1);
        return;
      end
      if (lay_has_text) push_result(0, 1'b1, CHR_LF, 1'b0, '0);
      return;
    end
    held = lay_has_text ? 0 : int'(lay_lines);
    lay_has_text = 1'b1;
    lay_empty = '0;
    cw = 1;
    cont = 2'd0;
    if (b < ASCII_TOP) begin
      cw = 1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      cw = 2;
      cont = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      cw = 2;
      cont = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      cw = 2;
      cont = 2'd3;
    end
    if (int'(lay_width) + cw > int'(page_width_cfg)) begin
      held++;
      lay_lines = lay_lines + 6'd1;
      lay_width = '0;
      if (lay_lines >= page_lines_cfg) begin
        push_result(held, 1'b0, 8'h00, 1'b1, ofs);
        return;
      end
    end
    lay_width = lay_width + cw[7:0];
    lay_cont = cont;
    push_result(held, 1'b1, b, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_LINE_LIMIT) page_lines_cfg = val[5:0];
    else page_width_cfg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic ps, input logic eof, input logic [7:0] b,
                           input logic [OFS_BITS-1:0] ofs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.page_start  <= ps;
    in_ch.end_of_file <= eof;
    in_ch.data_byte   <= b;
    in_ch.byte_offset <= ofs;
    do @(posedge clk); while (!in_ch.ready);
    lay_out_item(ps, eof, b, ofs);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (layout_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    int stall;
    page_out_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!no_idle) begin
        stall = $urandom_range(0, 4);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (layout_due.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_ch.out_byte), 32'd0);
      end else begin
        want = layout_due.pop_front();
        if (out_ch.newlines_before !== want.newlines)
          report_mismatch("newlines_before", 32'(out_ch.newlines_before),
                          32'(want.newlines));
        if (out_ch.byte_valid !== want.has_byte)
          report_mismatch("byte_valid", 32'(out_ch.byte_valid), 32'(want.has_byte));
        if (out_ch.out_byte !== want.text_byte)
          report_mismatch("out_byte", 32'(out_ch.out_byte), 32'(want.text_byte));
        if (out_ch.page_end !== want.ends_page)
          report_mismatch("page_end", 32'(out_ch.page_end), 32'(want.ends_page));
        if (out_ch.next_offset !== want.next_start)
          report_mismatch("next_offset", out_ch.next_offset, want.next_start);
      end
    end
  end

  task automatic test_basic_layout();
    send_item(1'b1, 1'b0, 8'h41, 0);
    send_item(1'b0, 1'b0, CHR_CR, 1);
    send_item(1'b0, 1'b0, 8'hE4, 2);
    send_item(1'b0, 1'b0, 8'hB8, 3);
    send_item(1'b0, 1'b0, 8'hAD, 4);
    send_item(1'b0, 1'b0, 8'hFF, 5);
    send_item(1'b0, 1'b0, 8'h00, 6);
    send_item(1'b0, 1'b0, CHR_LF, 7);
    send_item(1'b0, 1'b1, 8'h00, 8);
    wait_idle();
  endtask

  task automatic test_line_limits();
    write_reg(CFG_LINE_LIMIT, 8'd1);
    write_reg(CFG_LINE_WIDTH, 8'd2);
    send_item(1'b1, 1'b0, CHR_LF, 32'hFFFF_FFFF);
    send_item(1'b1, 1'b0, 8'h61, 10);
    send_item(1'b0, 1'b0, 8'h62, 11);
    send_item(1'b0, 1'b0, 8'hC3, 12);
    send_item(1'b0, 1'b0, 8'hA9, 13);
    wait_idle();
  endtask

  task automatic test_chapter_break();
    write_reg(CFG_LINE_LIMIT, 8'd63);
    write_reg(CFG_LINE_WIDTH, 8'd255);
    send_item(1'b1, 1'b0, 8'h78, 20);
    send_item(1'b0, 1'b0, CHR_LF, 21);
    send_item(1'b0, 1'b0, CHR_LF, 22);
    send_item(1'b0, 1'b0, CHR_LF, 23);
    send_item(1'b0, 1'b0, CHR_LF, 24);
    send_item(1'b0, 1'b0, CHR_SP, 25);
    send_item(1'b0, 1'b0, 8'h79, 26);
    send_item(1'b1, 1'b0, CHR_LF, 30);
    send_item(1'b0, 1'b0, CHR_LF, 31);
    send_item(1'b0, 1'b0, CHR_LF, 32);
    send_item(1'b0, 1'b0, CHR_TAB, 33);
    send_item(1'b0, 1'b0, 8'h7A, 34);
    wait_idle();
  endtask

  task automatic test_lowered_limit();
    send_item(1'b1, 1'b0, 8'h70, 40);
    send_item(1'b0, 1'b0, CHR_LF, 41);
    send_item(1'b0, 1'b0, 8'h71, 42);
    wait_idle();
    write_reg(CFG_LINE_LIMIT, 8'd1);
    send_item(1'b0, 1'b0, 8'h72, 43);
    wait_idle();
  endtask

  task automatic random_text(input int count);
    int n;
    int pick;
    int k;
    logic ps;
    logic eof;
    logic [7:0] b;
    n = 0;
    while (n < count) begin
      ps  = 1'b0;
      eof = 1'b0;
      if (start_pending) begin
        ps = 1'b1;
        start_pending = 1'b0;
      end else if (lay_finished) begin
        if ($urandom_range(0, 15) != 0) ps = 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        ps = 1'b1;
      end
      if (ps) begin
        byte_fifo.delete();
        pick = $urandom_range(0, 9);
        if (pick == 0) file_pos = $urandom;
        else if (pick == 1) file_pos = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else file_pos = next_page_ofs;
      end
      if (byte_fifo.size() > 0) begin
        b = byte_fifo.pop_front();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          b = 8'($urandom_range(8'h21, 8'h7E));
        end else if (pick < 48) begin
          b = $urandom_range(0, 1) ? CHR_SP : CHR_TAB;
        end else if (pick < 60) begin
          b = CHR_LF;
          if ($urandom_range(0, 2) == 0) begin
            // burst of blank lines, sometimes with whitespace mixed in
            k = $urandom_range(1, 5);
            repeat (k) begin
              case ($urandom_range(0, 5))
                0: byte_fifo.push_back(CHR_CR);
                1: byte_fifo.push_back(CHR_SP);
                default: byte_fifo.push_back(CHR_LF);
              endcase
            end
          end
        end else if (pick < 64) begin
          b = CHR_CR;
        end else if (pick < 76) begin
          k = $urandom_range(1, 3);
          case (k)
            1: b = LEAD2_CODE | 8'($urandom_range(0, 31));
            2: b = LEAD3_CODE | 8'($urandom_range(0, 15));
            default: b = LEAD4_CODE | 8'($urandom_range(0, 7));
          endcase
          if ($urandom_range(0, 7) == 0) k = $urandom_range(0, k - 1);
          repeat (k) byte_fifo.push_back(ASCII_TOP | 8'($urandom_range(0, 63)));
        end else if (pick < 82) begin
          b = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                   : 8'($urandom_range(8'hF8, 8'hFF));
        end else if (pick < 90) begin
          b = 8'($urandom);
        end else if (pick < 93) begin
          eof = 1'b1;
          b = 8'($urandom);
        end else begin
          b = 8'($urandom_range(0, 31));
        end
      end
      send_item(ps, eof, b, file_pos);
      file_pos = file_pos + 1'b1;
      if (last_live) n++;
    end
  endtask

  task automatic test_random_phases();
    logic [7:0] line_set [NUM_PHASES] = '{8'd12, 8'd1, 8'd63, 8'd0, 8'd4,
                                          8'd2, 8'd7, 8'd63, 8'd3, 8'd5};
    logic [7:0] width_set [NUM_PHASES] = '{8'd44, 8'd2, 8'd255, 8'd1, 8'd8,
                                           8'd0, 8'd20, 8'd3, 8'd255, 8'd6};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_LINE_LIMIT, line_set[p]);
      write_reg(CFG_LINE_WIDTH, width_set[p]);
      start_pending = 1'b1;
      no_idle = (p == 2 || p == 6);
      if (no_idle) hold_off = 60;
      random_text(PHASE_ITEMS / 2);
      if (no_idle) hold_off = 45;
      random_text(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    error_count  = 0;
    results_seen = 0;
    cycle_count  = 0;
    hold_off     = 0;
    no_idle      = 1'b0;
    last_live    = 1'b0;
    start_pending = 1'b0;
    file_pos     = '0;
    next_page_ofs = '0;
    page_lines_cfg = LINE_LIMIT_RST;
    page_width_cfg = LINE_WIDTH_RST;
    clear_layout();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_LINE_LIMIT;
    cfg_wdata         <= 8'h00;
    in_ch.valid       <= 1'b0;
    in_ch.page_start  <= 1'b0;
    in_ch.end_of_file <= 1'b0;
    in_ch.data_byte   <= 8'h00;
    in_ch.byte_offset <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_layout();
    test_line_limits();
    test_chapter_break();
    test_lowered_limit();
    test_random_phases();

    wait_idle();
    if (error_count == 0) begin
      $display("PASS utf8_text_paginator");
    end else begin
      $display("FAIL utf8_text_paginator");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/utp_pkg.sv
rtl/core/utp_in_if.sv
rtl/core/utp_layout.sv
rtl/core/utp_out_stage.sv
rtl/core/utp_text_paginator_top.sv
bench/tb_top.sv
